>>> design/gft_pkg.sv
// Package with shared types and constants of the grayscale frame transform.
`default_nettype none
package gft_pkg;
  localparam logic [1:0] MODE_NEG  = 2'd0;
  localparam logic [1:0] MODE_LR   = 2'd1;
  localparam logic [1:0] MODE_TB   = 2'd2;
  localparam logic [1:0] MODE_BLUR = 2'd3;
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_MAXI   = 2'd3;
  localparam int CFG_BITS = 16;
  localparam int SUM_BITS = 32;
  localparam int CNT_BITS = 16;
  typedef struct packed {
    logic       start;
    logic [SUM_BITS-1:0] dividend;
    logic [CNT_BITS-1:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

>>> design/grayscale_frame_transform_top.sv
// Top level of the grayscale frame transform.
// Requests enter on in_tvalid/in_tready/in_tdata; in_tuser is op (0 load, 1 read).
// A load writes the next raster pixel into the frame store and gives no result.
// A read request, once the frame is complete, returns one pixel on out_* with
// out_tlast marking the final pixel of the frame; reads before then give none.
// One request is in work at a time. A load frees the input once the pixel is
// written. A negative or mirror read of row 0 reads its pixel straight away;
// for a later row r the row is found first by subtracting the width once a
// cycle. A blur read sums every pixel of its window, up to 11 x 11, after the
// same row search, and the divider then divides the sum by the pixel count.
// The finished result moves into an output register, so requests are still
// taken while the receiver stalls. A second read result then waits in the
// block and the input stalls until the output register is free.
// Reset (rst_n, synchronous) clears the state, the positions, out_tvalid and the
// configuration; the frame store is not cleared. The user must write configuration
// through cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce it.
`default_nettype none
module grayscale_frame_transform_top #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int PIXEL_BITS  = 16,
  parameter int BLUR_RADIUS = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // pixel_in
  input  wire logic        in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // pixel_out
  output logic             out_tlast,  // last
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [gft_pkg::CFG_BITS-1:0] cfg_wdata
);
  import gft_pkg::*;
  localparam int WB = $clog2(MAX_WIDTH) + 1;
  localparam int HB = $clog2(MAX_HEIGHT) + 1;
  localparam int PB = WB + HB;
  localparam int AB = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_RD = 4'd2, S_RDW = 4'd3,
                         S_BSET = 4'd4, S_BRD = 4'd5, S_BACC = 4'd6, S_DIV = 4'd7,
                         S_DWT = 4'd8, S_OUT = 4'd9, S_RDD = 4'd10;

  logic [1:0]  mode_r;
  logic [8:0]  fw_r, fh_r;
  logic [15:0] maxi_r;
  logic [3:0]  st_r, st_nxt;
  logic [PB-1:0] lpos_r, lpos_nxt, opos_r, opos_nxt;
  logic [WB-1:0] w, c_r, c_nxt, bc_r, bc_nxt, c0_r, c0_nxt, c1_r, c1_nxt;
  logic [HB-1:0] h, r_r, r_nxt, br_r, br_nxt, r1_r, r1_nxt;
  logic [PB-1:0] total, pos;
  logic          last_r, last_nxt, ov_r, ov_nxt;
  logic [15:0]   pix_r, pix_nxt, din_r, din_nxt;
  logic          outv_r, outv_nxt, outl_r, outl_nxt;
  logic [15:0]   outd_r, outd_nxt;
  logic [SUM_BITS-1:0] sum_r, sum_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic          we;
  logic [AB-1:0] addr;
  logic [15:0]   rdata;
  div_req_t      dreq;
  logic          ddone;
  logic [SUM_BITS-1:0] quot;
  logic [HB-1:0] rr;
  logic [WB-1:0] cc;
  logic [PB+WB-1:0] rowbase;

  always_comb begin
    w = WB'(fw_r);
    if (fw_r == 9'd0) w = WB'(1);
    else if ((WB+9)'(fw_r) > (WB+9)'(MAX_WIDTH)) w = WB'(MAX_WIDTH);
    h = HB'(fh_r);
    if (fh_r == 9'd0) h = HB'(1);
    else if ((HB+9)'(fh_r) > (HB+9)'(MAX_HEIGHT)) h = HB'(MAX_HEIGHT);
  end
  assign total = PB'(w) * PB'(h);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NEG; fw_r <= 9'd256; fh_r <= 9'd256; maxi_r <= 16'd255;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:   mode_r <= cfg_wdata[1:0];
        REG_WIDTH:  fw_r <= cfg_wdata[8:0];
        REG_HEIGHT: fh_r <= cfg_wdata[8:0];
        REG_MAXI:   maxi_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign pos = (opos_r >= total - PB'(1)) ? total - PB'(1) : opos_r;
  assign in_tready = (st_r == S_IDLE);

  gft_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_store (
    .clk(clk), .we(we), .addr(addr), .wdata(din_r), .rdata(rdata));

  gft_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(quot));

  assign rowbase = (PB+WB)'(rr) * (PB+WB)'(w) + (PB+WB)'(cc);

  always_comb begin
    st_nxt = st_r; lpos_nxt = lpos_r; opos_nxt = opos_r;
    c_nxt = c_r; r_nxt = r_r; bc_nxt = bc_r; br_nxt = br_r;
    c0_nxt = c0_r; c1_nxt = c1_r; r1_nxt = r1_r;
    last_nxt = last_r; ov_nxt = ov_r; pix_nxt = pix_r; din_nxt = din_r;
    outv_nxt = outv_r && !out_tready; outd_nxt = outd_r; outl_nxt = outl_r;
    sum_nxt = sum_r; cnt_nxt = cnt_r;
    we = 1'b0; rr = r_r; cc = c_r;
    dreq = '0;
    case (mode_r)
      MODE_LR: cc = w - WB'(1) - c_r;
      MODE_TB: rr = h - HB'(1) - r_r;
      MODE_BLUR: begin rr = br_r; cc = bc_r; end
      default: ;
    endcase
    addr = (st_r == S_LOAD) ? AB'(lpos_r) : AB'(rowbase);
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (!in_tuser) begin
            din_nxt = in_tdata & 16'((32'd1 << PIXEL_BITS) - 32'd1);
            st_nxt = S_LOAD;
          end else if (lpos_r >= total) begin
            last_nxt = (opos_r >= total - PB'(1));
            st_nxt = S_RDD;
          end
        end
      end
      S_LOAD: begin
        if (lpos_r < total) begin
          we = 1'b1; lpos_nxt = lpos_r + PB'(1);
        end
        st_nxt = S_IDLE;
      end
      S_RDD: begin
        // The row of the position is found by subtracting the width once a cycle.
        r_nxt = '0; c_nxt = WB'(pos); opos_nxt = pos;
        st_nxt = S_RDW;
        if (pos < PB'(w)) st_nxt = (mode_r == MODE_BLUR) ? S_BSET : S_RD;
      end
      S_RDW: begin
        if (opos_r >= PB'(w)) begin
          opos_nxt = opos_r - PB'(w); r_nxt = r_r + HB'(1);
        end else begin
          c_nxt = WB'(opos_r);
          st_nxt = (mode_r == MODE_BLUR) ? S_BSET : S_RD;
        end
      end
      S_RD: st_nxt = S_OUT;
      S_BSET: begin
        br_nxt = (r_r > HB'(BLUR_RADIUS)) ? r_r - HB'(BLUR_RADIUS) : '0;
        c0_nxt = (c_r > WB'(BLUR_RADIUS)) ? c_r - WB'(BLUR_RADIUS) : '0;
        bc_nxt = (c_r > WB'(BLUR_RADIUS)) ? c_r - WB'(BLUR_RADIUS) : '0;
        r1_nxt = ((HB+1)'(r_r) + (HB+1)'(BLUR_RADIUS) > (HB+1)'(h - HB'(1)))
                 ? h - HB'(1) : HB'((HB+1)'(r_r) + (HB+1)'(BLUR_RADIUS));
        c1_nxt = ((WB+1)'(c_r) + (WB+1)'(BLUR_RADIUS) > (WB+1)'(w - WB'(1)))
                 ? w - WB'(1) : WB'((WB+1)'(c_r) + (WB+1)'(BLUR_RADIUS));
        sum_nxt = '0; cnt_nxt = '0;
        st_nxt = S_BRD;
      end
      S_BRD: st_nxt = S_BACC;
      S_BACC: begin
        sum_nxt = sum_r + SUM_BITS'(rdata);
        cnt_nxt = cnt_r + CNT_BITS'(1);
        st_nxt = S_BRD;
        if (bc_r == c1_r) begin
          bc_nxt = c0_r;
          if (br_r == r1_r) st_nxt = S_DIV;
          else br_nxt = br_r + HB'(1);
        end else begin
          bc_nxt = bc_r + WB'(1);
        end
      end
      S_DIV: begin
        dreq.start = 1'b1; dreq.dividend = sum_r; dreq.divisor = cnt_r;
        st_nxt = S_DWT;
      end
      S_DWT: if (ddone) begin
        pix_nxt = quot[15:0]; ov_nxt = 1'b1;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r) begin
          if (mode_r == MODE_NEG) pix_nxt = (maxi_r > rdata) ? maxi_r - rdata : '0;
          else pix_nxt = rdata;
          ov_nxt = 1'b1;
        end else if (!outv_r || out_tready) begin
          ov_nxt = 1'b0;
          outv_nxt = 1'b1; outd_nxt = pix_r; outl_nxt = last_r;
          st_nxt = S_IDLE;
          if (last_r) begin lpos_nxt = '0; opos_nxt = '0; end
          else opos_nxt = (PB'(r_r) * PB'(w)) + PB'(c_r) + PB'(1);
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; lpos_r <= '0; opos_r <= '0; ov_r <= 1'b0; outv_r <= 1'b0;
    end else begin
      st_r <= st_nxt; lpos_r <= lpos_nxt; opos_r <= opos_nxt; ov_r <= ov_nxt;
      outv_r <= outv_nxt;
    end
    c_r <= c_nxt; r_r <= r_nxt; bc_r <= bc_nxt; br_r <= br_nxt;
    c0_r <= c0_nxt; c1_r <= c1_nxt; r1_r <= r1_nxt; last_r <= last_nxt;
    pix_r <= pix_nxt; din_r <= din_nxt; sum_r <= sum_nxt; cnt_r <= cnt_nxt;
    outd_r <= outd_nxt; outl_r <= outl_nxt;
  end

  assign out_tvalid = outv_r;
  assign out_tdata  = outd_r;
  assign out_tlast  = outl_r;
endmodule
`default_nettype wire

>>> design/gft_ram.sv
// Generic single-port RAM with a registered read.
`default_nettype none
module gft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> design/gft_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module gft_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire gft_pkg::div_req_t          req,
  output logic                            done,
  output logic [gft_pkg::SUM_BITS-1:0]    quot
);
  import gft_pkg::*;
  logic [SUM_BITS-1:0] q_r, q_nxt;
  logic [SUM_BITS:0]   rem_r, rem_nxt;
  logic [CNT_BITS-1:0] d_r, d_nxt;
  logic [5:0]          n_r, n_nxt;
  logic                busy_r, busy_nxt, done_r, done_nxt;
  logic [SUM_BITS:0]   sh;
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; n_nxt = n_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {rem_r[SUM_BITS-1:0], q_r[SUM_BITS-1]};
    if (req.start) begin
      q_nxt = req.dividend; rem_nxt = '0; d_nxt = req.divisor;
      n_nxt = 6'(SUM_BITS); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {{(SUM_BITS+1-CNT_BITS){1'b0}}, d_r}) begin
        rem_nxt = sh - {{(SUM_BITS+1-CNT_BITS){1'b0}}, d_r};
        q_nxt = {q_r[SUM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[SUM_BITS-2:0], 1'b0};
      end
      n_nxt = n_r - 6'd1;
      if (n_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; n_r <= n_nxt;
  end
  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

>>> design/gft_checker.sv
// Port checker for the grayscale frame transform, bound to the top level.
`default_nettype none
module gft_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
  a_rdy: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !$isunknown({out_tdata, out_tlast}))
    else $error("unknown bits in a result");
endmodule
bind grayscale_frame_transform_top gft_checker u_chk (.*);
`default_nettype wire

>>> test/grayscale_frame_transform_top_tb.sv
// Self-checking testbench of the grayscale frame transform with its own pixel predictor.
`timescale 1ns / 100ps
`default_nettype none
module grayscale_frame_transform_top_tb;
  import gft_pkg::*;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam int LIMIT_CYCLES = 6000000;

  typedef struct {
    logic [15:0] pixel;
    logic        last;
  } pixel_res_t;

  class frame_scoreboard;
    logic [15:0] store [0:65535];
    int unsigned loaded, emitted;
    logic [1:0]  mode;
    int unsigned width, height;
    logic [15:0] maxi;
    pixel_res_t  pending[$];
    int          errors;

    function void clear();
      loaded = 0; emitted = 0; mode = MODE_NEG; width = 256; height = 256;
      maxi = 16'd255; errors = 0;
    endfunction

    function void set_reg(logic [1:0] addr, logic [15:0] value);
      case (addr)
        REG_MODE: mode = value[1:0];
        REG_WIDTH: width = value[8:0];
        REG_HEIGHT: height = value[8:0];
        default: maxi = value;
      endcase
    endfunction

    function int unsigned eff(int unsigned v);
      return v < 1 ? 1 : (v > 256 ? 256 : v);
    endfunction

    function logic [15:0] blurred(int unsigned w, int unsigned h, int r, int c);
      int r0, r1, c0, c1;
      longint unsigned sum, cnt;
      r0 = r > 5 ? r - 5 : 0; c0 = c > 5 ? c - 5 : 0;
      r1 = r + 5 > h - 1 ? h - 1 : r + 5;
      c1 = c + 5 > w - 1 ? w - 1 : c + 5;
      sum = 0; cnt = 0;
      for (int i = r0; i <= r1; i++) begin
        for (int j = c0; j <= c1; j++) begin
          sum += store[i * w + j];
          cnt++;
        end
      end
      return 16'(sum / cnt);
    endfunction

    function void note_request(logic op, logic [15:0] data);
      int unsigned w, h, total, pos, r, c;
      pixel_res_t res;
      w = eff(width); h = eff(height); total = w * h;
      if (op == OP_LOAD) begin
        if (loaded < total) begin
          store[loaded] = data;
          loaded++;
        end
        return;
      end
      if (loaded < total) return;
      pos = emitted;
      res.last = pos >= total - 1;
      if (res.last) pos = total - 1;
      r = pos / w; c = pos % w;
      case (mode)
        MODE_NEG: res.pixel = maxi > store[pos] ? maxi - store[pos] : 16'd0;
        MODE_LR: res.pixel = store[r * w + (w - 1 - c)];
        MODE_TB: res.pixel = store[(h - 1 - r) * w + c];
        default: res.pixel = blurred(w, h, r, c);
      endcase
      pending.push_back(res);
      if (res.last) begin
        loaded = 0; emitted = 0;
      end else emitted = pos + 1;
    endfunction

    function void check_result(logic [15:0] pixel, logic last);
      pixel_res_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result pixel %h last %b", $time, pixel, last);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (pixel !== exp_res.pixel) begin
        $display("%0t: pixel expected %h actual %h", $time, exp_res.pixel, pixel);
        errors++;
      end
      if (last !== exp_res.last) begin
        $display("%0t: last expected %b actual %b", $time, exp_res.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  frame_scoreboard sb;
  int cycles = 0;
  bit hold_off = 1'b0;

  always #10 clk = ~clk;

  grayscale_frame_transform_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  function int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  task automatic send_request(logic op, logic [15:0] data, bit idle_ok);
    int gap;
    gap = idle_ok ? gap_length() : 0;
    repeat (gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, data);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0 && cycles < LIMIT_CYCLES) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(addr, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(logic [1:0] m, int w, int h, logic [15:0] mx);
    drain();
    write_reg(REG_MODE, 16'(m));
    write_reg(REG_WIDTH, 16'(w));
    write_reg(REG_HEIGHT, 16'(h));
    write_reg(REG_MAXI, mx);
  endtask

  task automatic load_frame(int count, bit extremes);
    logic [15:0] v;
    for (int i = 0; i < count; i++) begin
      if (extremes) v = (i % 3 == 0) ? 16'hFFFF : ((i % 3 == 1) ? 16'h0000 : 16'(i * 4099));
      else v = 16'($urandom);
      send_request(OP_LOAD, v, 1'b1);
    end
  endtask

  task automatic read_pixels(int count);
    for (int i = 0; i < count; i++) send_request(OP_READ, 16'($urandom), 1'b1);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  initial begin : receiver
    int stall;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        stall = gap_length();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int w, h, mode_sel, reads;
    sb = new();
    sb.clear();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: read before the frame is complete, extremes, every mode.
    set_frame(MODE_NEG, 3, 2, 16'h8000);
    send_request(OP_READ, 16'h0, 1'b0);
    load_frame(6, 1'b1);
    send_request(OP_LOAD, 16'h1234, 1'b0);
    read_pixels(6);
    set_frame(MODE_LR, 3, 2, 16'hFFFF);
    load_frame(6, 1'b1);
    read_pixels(2);
    // Shrinking the frame leaves the output position past the end.
    set_frame(MODE_TB, 1, 1, 16'd1);
    read_pixels(1);
    set_frame(MODE_BLUR, 13, 1, 16'd255);
    load_frame(13, 1'b1);
    read_pixels(13);

    // Random frames, mostly small, with one long output hold-off.
    for (int f = 0; f < 20; f++) begin
      mode_sel = $urandom_range(0, 3);
      if (f == 15) begin
        w = 40; h = 1;
      end else if (f == 16) begin
        w = 1; h = 12;
      end else if (f == 17) begin
        w = 0; h = 300;
      end else begin
        w = $urandom_range(1, 7); h = $urandom_range(1, 7);
      end
      if (f == 17) begin
        set_frame(2'(mode_sel), w, h, 16'($urandom));
        w = 1; h = 256;
      end else set_frame(2'(mode_sel), w, h,
                         16'($urandom_range(0, 1) ? $urandom : 16'hFFFF));
      if (f == 5) hold_off = 1'b1;
      load_frame(w * h + ($urandom_range(0, 3) == 0 ? 2 : 0), 1'b0);
      reads = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w * h) : w * h;
      if (f == 17) reads = 20;
      read_pixels(reads);
      if (reads != w * h && $urandom_range(0, 1)) begin
        drain();
        write_reg(REG_HEIGHT, 16'd1);
        read_pixels(1);
      end
      if (reads != w * h && sb.loaded != 0) read_pixels(w * h - reads);
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
